// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the sector cache lookup RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on the rising edge of aclk outside reset.
`define SCL_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on the rising edge of aclk outside reset.
`define SCL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/scl_pkg.sv =====
// Shared types and constants for the sector cache lookup.
package scl_pkg;

    // Default geometry.
    localparam int SLOTS_DEFAULT        = 16;
    localparam int SECTOR_BYTES_DEFAULT = 131072;

    // Widest slot index the store request can carry (up to 64 slots).
    localparam int IDX_MAX_W = 6;

    // Fixed field widths.
    localparam int ADDR_W   = 32;
    localparam int SLOT_W   = 4;
    localparam int OFFSET_W = 17;
    localparam int FILL_W   = 18;
    localparam int NSLOT_W  = 5;
    localparam int CFG_IDX_W = 2;

    // Low addresses, up to and including this limit, are folded onto a small window starting at it.
    localparam logic [ADDR_W-1:0] REMAP_LIMIT = 32'h0000_8000;
    localparam logic [ADDR_W-1:0] REMAP_MASK  = 32'h0000_01FF;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_ROM_SIZE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOTS_IN_USE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CACHE_BASE   = 2'd2;

    // Lookup sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_CHECK,
        ST_WRITE
    } state_t;

    // Request from the sequencer to the tag and stamp store.
    typedef struct packed {
        logic                 rd_en;
        logic [IDX_MAX_W-1:0] rd_addr;
        logic                 wr_en;
        logic [IDX_MAX_W-1:0] wr_addr;
        logic [ADDR_W-1:0]    wr_tag;
        logic [ADDR_W-1:0]    wr_stamp;
    } store_req_t;

    // Registered read data from the store.
    typedef struct packed {
        logic              valid;
        logic [ADDR_W-1:0] tag;
        logic [ADDR_W-1:0] stamp;
    } store_rsp_t;

    // One lookup result.
    typedef struct packed {
        logic                hit;
        logic [SLOT_W-1:0]   slot_index;
        logic [ADDR_W-1:0]   sector_base;
        logic [OFFSET_W-1:0] sector_offset;
        logic [ADDR_W-1:0]   buffer_address;
        logic [FILL_W-1:0]   fill_length;
    } result_t;

endpackage

// ===== rtl/scl_store.sv =====
// Tag and use stamp memory with per-slot valid flags and a registered read port.
module scl_store #(
    parameter int SLOTS = 16,
    parameter int IDX_W = 4
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  scl_pkg::store_req_t req,
    output scl_pkg::store_rsp_t rsp
);
    import scl_pkg::*;

    logic [ADDR_W-1:0] tag_mem   [SLOTS];
    logic [ADDR_W-1:0] stamp_mem [SLOTS];
    logic [SLOTS-1:0]  valid_reg;
    logic              rd_valid_reg;
    logic [ADDR_W-1:0] rd_tag_reg;
    logic [ADDR_W-1:0] rd_stamp_reg;
    logic [IDX_W-1:0]  rd_idx;
    logic [IDX_W-1:0]  wr_idx;

    assign rd_idx = req.rd_addr[IDX_W-1:0];
    assign wr_idx = req.wr_addr[IDX_W-1:0];

    // Memory write and registered read.
    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            tag_mem[wr_idx]   <= req.wr_tag;
            stamp_mem[wr_idx] <= req.wr_stamp;
        end
        if (req.rd_en) begin
            rd_tag_reg   <= tag_mem[rd_idx];
            rd_stamp_reg <= stamp_mem[rd_idx];
        end
    end

    // Valid flags clear at reset; a slot becomes valid on its first write.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (req.wr_en) begin
                valid_reg[wr_idx] <= 1'b1;
            end
            if (req.rd_en) begin
                rd_valid_reg <= valid_reg[rd_idx];
            end
        end
    end

    assign rsp.valid = rd_valid_reg;
    assign rsp.tag   = rd_tag_reg;
    assign rsp.stamp = rd_stamp_reg;

endmodule

// ===== rtl/scl_ctrl.sv =====
// Lookup sequencer: remaps the address, scans the slots for a hit and a victim, stamps the slot.
module scl_ctrl #(
    parameter int SECTOR_BYTES = 131072,
    parameter int IDX_W        = 4,
    parameter int CNT_W        = 5
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [scl_pkg::ADDR_W-1:0]    in_address,
    input  logic [CNT_W-1:0]              active_slots,
    input  logic [scl_pkg::ADDR_W-1:0]    rom_size,
    input  logic [scl_pkg::ADDR_W-1:0]    cache_base,
    input  logic                          out_free,
    output logic                          out_load,
    output scl_pkg::result_t              result,
    output scl_pkg::store_req_t           req,
    input  scl_pkg::store_rsp_t           rsp
);
    import scl_pkg::*;

    // Sectors are a power of two in size, so alignment is a mask.
    localparam int SECTOR_SHIFT = $clog2(SECTOR_BYTES);
    localparam logic [ADDR_W-1:0] OFF_MASK = ADDR_W'(SECTOR_BYTES - 1);
    localparam logic [ADDR_W:0]   SECTOR_SPAN = (ADDR_W + 1)'(SECTOR_BYTES);

    state_t            state_reg, state_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [ADDR_W-1:0] count_reg, count_next;
    logic [ADDR_W-1:0] bound_reg, bound_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [IDX_W-1:0]  slot_reg, slot_next;
    logic              hit_reg, hit_next;
    logic              vdone_reg, vdone_next;

    logic [ADDR_W-1:0] remapped;
    logic [ADDR_W-1:0] sector;
    logic [ADDR_W-1:0] stamp_eff;
    logic [ADDR_W:0]   sector_end;
    logic [ADDR_W:0]   fill_full;
    logic [ADDR_W-1:0] slot_span;

    // Fold low addresses onto the window starting at the remap limit.
    assign remapped = (in_address <= REMAP_LIMIT) ?
                      (REMAP_LIMIT + (in_address & REMAP_MASK)) : in_address;

    assign sector    = addr_reg & ~OFF_MASK;
    assign stamp_eff = rsp.valid ? rsp.stamp : '0;

    // Fill length: a whole sector unless a nonzero ROM size ends inside or before it.
    assign sector_end = {1'b0, sector} + SECTOR_SPAN;
    always_comb begin
        fill_full = SECTOR_SPAN;
        if ((rom_size != '0) && (sector_end > {1'b0, rom_size})) begin
            fill_full = (rom_size > sector) ? {1'b0, rom_size - sector} : '0;
        end
    end

    assign slot_span = ADDR_W'(slot_reg) << SECTOR_SHIFT;

    // Result fields, valid while the sequencer is in the write state.
    assign result.hit            = hit_reg;
    assign result.slot_index     = SLOT_W'(slot_reg);
    assign result.sector_base    = sector;
    assign result.sector_offset  = OFFSET_W'(addr_reg & OFF_MASK);
    assign result.buffer_address = cache_base + slot_span;
    assign result.fill_length    = fill_full[FILL_W-1:0];

    // State and datapath registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        addr_reg  <= addr_next;
        bound_reg <= bound_next;
        idx_reg   <= idx_next;
        slot_reg  <= slot_next;
        hit_reg   <= hit_next;
        vdone_reg <= vdone_next;
    end

    // Next state, scan step and store requests.
    always_comb begin
        state_next = state_reg;
        addr_next  = addr_reg;
        count_next = count_reg;
        bound_next = bound_reg;
        idx_next   = idx_reg;
        slot_next  = slot_reg;
        hit_next   = hit_reg;
        vdone_next = vdone_reg;
        in_ready   = 1'b0;
        out_load   = 1'b0;
        req        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    addr_next  = remapped;
                    count_next = count_reg + 1'b1;
                    bound_next = count_reg + 1'b1;
                    idx_next   = '0;
                    slot_next  = '0;
                    hit_next   = 1'b0;
                    vdone_next = 1'b0;
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                if (idx_reg == active_slots) begin
                    state_next = ST_WRITE;
                end else begin
                    req.rd_en   = 1'b1;
                    req.rd_addr = IDX_MAX_W'(idx_reg[IDX_W-1:0]);
                    state_next  = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (rsp.valid && (rsp.tag == sector)) begin
                    hit_next   = 1'b1;
                    slot_next  = idx_reg[IDX_W-1:0];
                    state_next = ST_WRITE;
                end else begin
                    // Oldest stamp wins, ties to the higher slot, stop at a zero stamp.
                    if (!vdone_reg && (stamp_eff <= bound_reg)) begin
                        bound_next = stamp_eff;
                        slot_next  = idx_reg[IDX_W-1:0];
                        vdone_next = (stamp_eff == '0);
                    end
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_WRITE: begin
                if (out_free) begin
                    req.wr_en    = 1'b1;
                    req.wr_addr  = IDX_MAX_W'(slot_reg);
                    req.wr_tag   = sector;
                    req.wr_stamp = count_reg;
                    out_load     = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/sector_cache_lru_lookup.sv =====
// A lookup scans the active slots one at a time over the single read port of the tag and
// stamp memory, a read state and a check state per slot, and stops early on a hit; the
// sequencer takes no new lookup until it has loaded the result of the last one.
// The output register holds one result so the next lookup can start while it waits.
// Reset (synchronous, aresetn low) clears the slot valid flags, the access counter and
// the configuration registers to their defaults; there is no memory clearing pass.
`include "assert_macros.svh"

module sector_cache_lru_lookup #(
    parameter int SLOTS        = scl_pkg::SLOTS_DEFAULT,
    parameter int SECTOR_BYTES = scl_pkg::SECTOR_BYTES_DEFAULT
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Input stream.
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [31:0]                     s_tdata,    // [31:0] read_address
    // Result stream.
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [3:0] slot_index, [35:4] sector_base, [52:36] sector_offset,
    // [84:53] buffer_address, [102:85] fill_length, [103] zero
    output logic [103:0]                    m_tdata,
    output logic                            m_tuser,    // [0] hit
    // Configuration write channel.
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [scl_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [31:0]                     cfg_data
);
    import scl_pkg::*;

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(SLOTS + 1);

    logic [ADDR_W-1:0]  rom_size_reg;
    logic [NSLOT_W-1:0] slots_in_use_reg;
    logic [ADDR_W-1:0]  cache_base_reg;
    logic [CNT_W-1:0]   active_slots;

    logic       out_valid_reg;
    result_t    out_reg;
    logic       out_free;
    logic       out_load;
    result_t    result;
    store_req_t req;
    store_rsp_t rsp;

    // Configuration registers; writes are always accepted.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rom_size_reg     <= '0;
            slots_in_use_reg <= NSLOT_W'(16);
            cache_base_reg   <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_ROM_SIZE:     rom_size_reg     <= cfg_data;
                CFG_SLOTS_IN_USE: slots_in_use_reg <= cfg_data[NSLOT_W-1:0];
                CFG_CACHE_BASE:   cache_base_reg   <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Slots in use, saturated at the number of slots built.
    assign active_slots = (32'(slots_in_use_reg) > SLOTS) ?
                          CNT_W'(SLOTS) : CNT_W'(slots_in_use_reg);

    scl_store #(
        .SLOTS (SLOTS),
        .IDX_W (IDX_W)
    ) u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (req),
        .rsp     (rsp)
    );

    scl_ctrl #(
        .SECTOR_BYTES (SECTOR_BYTES),
        .IDX_W        (IDX_W),
        .CNT_W        (CNT_W)
    ) u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .in_address   (s_tdata),
        .active_slots (active_slots),
        .rom_size     (rom_size_reg),
        .cache_base   (cache_base_reg),
        .out_free     (out_free),
        .out_load     (out_load),
        .result       (result),
        .req          (req),
        .rsp          (rsp)
    );

    // Output register: holds one result until its transfer.
    assign out_free = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.hit;
    assign m_tdata  = {1'b0, out_reg.fill_length, out_reg.buffer_address,
                       out_reg.sector_offset, out_reg.sector_base, out_reg.slot_index};

    // A new lookup never completes in the cycle right after its input transfer.
    `SCL_ASSERT_NEXT(a_no_instant_result, s_tvalid && s_tready, !out_load,
        "result loaded directly after input transfer")

    // The sequencer never takes an input while it loads a result.
    `SCL_ASSERT_NOW(a_load_not_idle, out_load, !s_tready,
        "result load while accepting input")

    // A result goes to a slot inside the active range, or to slot zero.
    `SCL_ASSERT_NOW(a_slot_in_range, out_load,
        (CNT_W'(result.slot_index) < active_slots) || (result.slot_index == '0),
        "result slot outside the active slots")

endmodule
